// ===== hw/rtl/weekly_alarm_table_defines.svh =====
// Assertion macros shared by the weekly alarm table RTL.
`ifndef WEEKLY_ALARM_TABLE_DEFINES_SVH
`define WEEKLY_ALARM_TABLE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define WAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define WAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/wat_pkg.sv =====
// Types, constants and helpers shared by the weekly alarm table modules.
`timescale 1ns / 1ps
package wat_pkg;

  localparam int ENTRY_COUNT = 8;
  localparam int IDX_W       = $clog2(ENTRY_COUNT);
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int DAY_COUNT   = 7;
  localparam int MIN_W       = 11;
  localparam int DAYS_W      = 7;
  localparam int PCT_W       = 7;
  localparam int DAY_W       = 3;
  localparam int OP_W        = 2;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESYNC  = 2'd2,
    OP_RECOVER = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TICK_EMIT,
    S_REC_SCAN,
    S_REC_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cap;
    logic write;
    logic resync;
    logic tick_load;
    logic emit;
    logic scan_clear;
    logic scan_step;
    logic rec_emit;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;
    logic out_free;
    logic pend_empty;
    logic emit_last;
    logic scan_last;
    logic rec_hit;
  } sts_t;

  // Weekday mask lookup; day seven has no mask bit and never matches
  function automatic logic on_day(logic [DAYS_W-1:0] mask, logic [DAY_W-1:0] day);
    logic [DAYS_W:0] ext;
    ext = {1'b0, mask};
    return ext[day];
  endfunction

endpackage

// ===== hw/rtl/wat_ctrl.sv =====
// Controller state machine of the weekly alarm table.
`timescale 1ns / 1ps
module wat_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  wat_pkg::sts_t sts,
  output wat_pkg::cmd_t cmd
);
  import wat_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts.op)
          OP_WRITE:   state_nxt = S_IDLE;
          OP_RESYNC:  state_nxt = S_IDLE;
          OP_TICK:    state_nxt = S_TICK_EMIT;
          OP_RECOVER: state_nxt = S_REC_SCAN;
          default:    state_nxt = S_IDLE;
        endcase
      end
      S_TICK_EMIT: begin
        if (sts.pend_empty || (sts.out_free && sts.emit_last)) state_nxt = S_IDLE;
      end
      S_REC_SCAN: begin
        if (sts.scan_last) state_nxt = S_REC_EMIT;
      end
      S_REC_EMIT: begin
        if (!sts.rec_hit || sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.cap   = in_tvalid;
      end
      S_EXEC: begin
        unique case (sts.op)
          OP_WRITE:   cmd.write      = 1'b1;
          OP_RESYNC:  cmd.resync     = 1'b1;
          OP_TICK:    cmd.tick_load  = 1'b1;
          OP_RECOVER: cmd.scan_clear = 1'b1;
          default:    cmd.write      = 1'b0;
        endcase
      end
      S_TICK_EMIT: begin
        cmd.emit = !sts.pend_empty && sts.out_free;
      end
      S_REC_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_REC_EMIT: begin
        cmd.rec_emit = sts.rec_hit && sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/wat_dp.sv =====
// Datapath of the weekly alarm table: entry table, fired flags, scans, output register.
`timescale 1ns / 1ps
module wat_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wat_pkg::cmd_t                      cmd,
  output wat_pkg::sts_t                      sts,
  input  logic [wat_pkg::OP_W-1:0]           in_tuser,
  input  logic [wat_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wat_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast
);
  import wat_pkg::*;

  // Captured transaction
  op_t              op_r;
  logic [2:0]       idx_r;
  logic [MIN_W-1:0] atime_r;
  logic [DAYS_W-1:0] adays_r;
  logic             aen_r;
  logic [PCT_W-1:0] apct_r;
  logic [DAY_W-1:0] day_r;
  logic [MIN_W-1:0] now_r;
  logic [DAY_W-1:0] lday_r;
  logic [MIN_W-1:0] ltime_r;

  // Entry table and fired flags
  logic [MIN_W-1:0]  ent_min_r  [ENTRY_COUNT];
  logic [DAYS_W-1:0] ent_days_r [ENTRY_COUNT];
  logic [PCT_W-1:0]  ent_lvl_r  [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] ent_act_r;
  logic [ENTRY_COUNT-1:0] fired_r;
  logic [ENTRY_COUNT-1:0] fired_nxt;

  // Tick emission
  logic [ENTRY_COUNT-1:0] pend_r;
  logic [ENTRY_COUNT-1:0] cand;
  logic [ENTRY_COUNT-1:0] due;
  logic [ENTRY_COUNT-1:0] pick_oh;
  logic [IDX_W-1:0]       pick_idx;
  logic [CNT_W-1:0]       cnt_r;

  // Recover scan
  logic [IDX_W-1:0] scan_idx_r;
  logic             found_r;
  logic [IDX_W-1:0] best_r;
  logic [MIN_W-1:0] best_min_r;
  logic [MIN_W-1:0] scan_min;
  logic             scan_cand;

  // Output register
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [PCT_W-1:0] out_pct_r;
  logic             out_last_r;
  logic             out_free;
  logic [IDX_W-1:0] lvl_addr;
  logic             load;

  // Capture the transaction payload
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r    <= op_t'(in_tuser);
      idx_r   <= in_tdata[2:0];
      atime_r <= in_tdata[13:3];
      adays_r <= in_tdata[20:14];
      aen_r   <= in_tdata[21];
      apct_r  <= in_tdata[28:22];
      day_r   <= in_tdata[31:29];
      now_r   <= in_tdata[42:32];
      lday_r  <= in_tdata[45:43];
      ltime_r <= in_tdata[56:46];
    end
  end

  // Per-entry due test for the current day and minute
  always_comb begin
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      due[i]  = on_day(ent_days_r[i], day_r) && (ent_min_r[i] <= now_r);
      cand[i] = ent_act_r[i] && due[i] && !(fired_r[i] && (now_r != '0));
    end
  end

  // Lowest pending entry
  assign pick_oh = pend_r & (~pend_r + 1'b1);
  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      if (pick_oh[i]) pick_idx = IDX_W'(i);
    end
  end

  // Write an entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        ent_min_r[i]  <= '0;
        ent_days_r[i] <= '0;
        ent_lvl_r[i]  <= '0;
      end
      ent_act_r <= '0;
    end else if (cmd.write && (32'(idx_r) < ENTRY_COUNT)) begin
      ent_min_r[idx_r[IDX_W-1:0]]  <= atime_r;
      ent_days_r[idx_r[IDX_W-1:0]] <= adays_r;
      ent_lvl_r[idx_r[IDX_W-1:0]]  <= apct_r;
      ent_act_r[idx_r[IDX_W-1:0]]  <= aen_r;
    end
  end

  // Fired flag update: minute-zero clear, emission mark, resync
  always_comb begin
    fired_nxt = fired_r;
    if (cmd.tick_load && (now_r == '0)) fired_nxt = '0;
    if (cmd.emit) fired_nxt = fired_r | pick_oh;
    if (cmd.resync) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        if (on_day(ent_days_r[i], day_r)) fired_nxt[i] = (ent_min_r[i] <= now_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fired_r <= '0;
    end else begin
      fired_r <= fired_nxt;
    end
  end

  // Load the pending set, then drop one entry per emitted result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.tick_load) begin
      pend_r <= cand;
      cnt_r  <= '0;
    end else if (cmd.emit) begin
      pend_r <= sts.emit_last ? '0 : (pend_r & ~pick_oh);
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  // Recover scan: latest due active entry, lowest index on a tie
  assign scan_min  = ent_min_r[scan_idx_r];
  assign scan_cand = ent_act_r[scan_idx_r] && on_day(ent_days_r[scan_idx_r], day_r) &&
                     (scan_min <= now_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      found_r    <= 1'b0;
    end else if (cmd.scan_clear) begin
      scan_idx_r <= '0;
      found_r    <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (scan_cand && (!found_r || (scan_min > best_min_r))) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && scan_cand && (!found_r || (scan_min > best_min_r))) begin
      best_r     <= scan_idx_r;
      best_min_r <= scan_min;
    end
  end

  // Output register, freed when the downstream side takes the transaction
  assign out_free = !out_valid_r || out_tready;
  assign load     = cmd.emit || cmd.rec_emit;
  assign lvl_addr = cmd.emit ? pick_idx : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_idx_r  <= lvl_addr;
      out_pct_r  <= ent_lvl_r[lvl_addr];
      out_last_r <= cmd.rec_emit || sts.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - IDX_W - PCT_W){1'b0}}, out_pct_r, out_idx_r};

  // Status back to the controller
  always_comb begin
    sts.op         = op_r;
    sts.out_free   = out_free;
    sts.pend_empty = (pend_r == '0);
    sts.emit_last  = ((pend_r & ~pick_oh) == '0) || (cnt_r == CNT_W'(MAX_RESULTS - 1));
    sts.scan_last  = (scan_idx_r == IDX_W'(ENTRY_COUNT - 1));
    sts.rec_hit    = found_r && ((lday_r != day_r) || (best_min_r > ltime_r));
  end

endmodule

// ===== hw/rtl/weekly_alarm_table.sv =====
// Top level of the weekly alarm table: controller, datapath and assertions.
// One transaction at a time is taken on the in_ side; in_tuser selects write,
// tick, resync or recover. Write and resync give no result. On a tick the
// fired alarms leave in index order through a single output register, which
// waits while the out_ side stalls, and the final one carries out_tlast.
// Recover scans the 8 entries one per cycle and gives at most one result with
// out_tlast set.
// The next transaction is accepted once the last result of the current one sits
// in the output register. After reset all entries and fired flags are zero.
`timescale 1ns / 1ps
`include "weekly_alarm_table_defines.svh"
module weekly_alarm_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // in_tdata: entry_index[2:0], alarm_time[13:3], alarm_days[20:14],
  // alarm_enable[21], target_percent[28:22], now_day[31:29], now_time[42:32],
  // last_day[45:43], last_time[56:46], zero[63:57]
  input  logic [wat_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: op[1:0]
  input  logic [wat_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_tdata: fired_index[2:0], fired_percent[9:3], zero[15:10]
  output logic [wat_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import wat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wat_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Controller issues at most one command per cycle
  `WAT_ASSERT(a_one_cmd, $onehot0(cmd), "controller issued more than one command")
  // A result is only loaded into a free output register
  `WAT_ASSERT(a_load_free, !(cmd.emit || cmd.rec_emit) || sts.out_free, "output register overwritten")
  // An accepted transaction closes the input until it has been worked
  `WAT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input reopened too early")

endmodule
